FILE: rtl/cba_pkg.sv
package cba_pkg;

    localparam int BLOCKS      = 64;
    localparam int DIR_ENTRIES = 16;

    // fixed field widths
    localparam int KEY_W    = 64;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 3;
    localparam int START_W  = 6;
    localparam int TOTAL_W  = 7;

    // widths that follow the sizes above
    localparam int BLK_W     = $clog2(BLOCKS);
    localparam int CNT_W     = $clog2(BLOCKS + 1);
    localparam int DIR_IDX_W = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int ENT_W     = $clog2(DIR_ENTRIES + 1);

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(64);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_CREATE = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_CREATED   = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DIR_FULL  = 3'd4,
        ST_BAD_LEN   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    // classified request as it travels from front to back
    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic             bad_len;
        logic [CNT_W-1:0] usable;
    } t_cmd;

endpackage

FILE: rtl/cba_front.sv
module cba_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cba_pkg::TOTAL_W-1:0]  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_operation,
    input  logic [cba_pkg::KEY_W-1:0]    i_file_key,
    input  logic [cba_pkg::LEN_W-1:0]    i_block_count,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output cba_pkg::t_cmd                o_q_cmd
);
    import cba_pkg::*;

    logic [TOTAL_W-1:0] r_total_blocks;
    logic [CNT_W-1:0]   usable;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_blocks <= TOTAL_RESET;
        end else if (i_cfg_valid) begin
            r_total_blocks <= i_cfg_data;
        end
    end

    // a register value above the disk size acts as the disk size
    assign usable = (int'(r_total_blocks) > BLOCKS) ? CNT_W'(BLOCKS)
                                                    : CNT_W'(r_total_blocks);

    assign o_stall  = i_q_full;
    assign o_q_push = i_valid && !i_q_full;

    always_comb begin
        o_q_cmd.op      = t_op'(i_operation);
        o_q_cmd.key     = i_file_key;
        o_q_cmd.len     = i_block_count;
        o_q_cmd.bad_len = (i_block_count == '0) || (int'(i_block_count) > int'(usable));
        o_q_cmd.usable  = usable;
    end

endmodule

FILE: rtl/cba_queue.sv
module cba_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cba_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output cba_pkg::t_cmd  o_cmd
);
    import cba_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full      = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rp];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: rtl/cba_back.sv
module cba_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_not_empty,
    input  cba_pkg::t_cmd                 i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cba_pkg::STATUS_W-1:0]  o_status,
    output logic [cba_pkg::START_W-1:0]   o_start_block,
    output logic [cba_pkg::LEN_W-1:0]     o_run_length
);
    import cba_pkg::*;

    t_state             r_state, n_state;
    logic [BLOCKS-1:0]  r_free, n_free;
    logic [ENT_W-1:0]   r_count, n_count;
    t_cmd               r_cmd, n_cmd;
    logic [CNT_W-1:0]   r_blk, n_blk;
    logic [CNT_W-1:0]   r_run, n_run;
    logic [ENT_W-1:0]   r_di, n_di;
    t_status            r_res_status, n_res_status;
    logic [BLK_W-1:0]   r_res_start, n_res_start;
    logic [CNT_W-1:0]   r_res_len, n_res_len;
    logic               r_out_valid, n_out_valid;
    t_status            r_o_status, n_o_status;
    logic [START_W-1:0] r_o_start, n_o_start;
    logic [LEN_W-1:0]   r_o_len, n_o_len;

    // directory, one read index and one write port a cycle
    logic [KEY_W-1:0]   r_dkey   [DIR_ENTRIES];
    logic [BLK_W-1:0]   r_dstart [DIR_ENTRIES];
    logic [CNT_W-1:0]   r_dlen   [DIR_ENTRIES];
    logic               dir_we;
    logic [DIR_IDX_W-1:0] dir_wa;
    logic [KEY_W-1:0]   dir_wkey;
    logic [BLK_W-1:0]   dir_wstart;
    logic [CNT_W-1:0]   dir_wlen;
    logic [DIR_IDX_W-1:0] dir_ra;
    logic [KEY_W-1:0]   rd_key;
    logic [BLK_W-1:0]   rd_start;
    logic [CNT_W-1:0]   rd_len;

    logic [CNT_W-1:0]   len_c;
    logic [CNT_W-1:0]   run_next;
    logic [CNT_W-1:0]   scan_start;
    logic [ENT_W-1:0]   di_nxt;
    logic [CNT_W:0]     del_start;
    logic [CNT_W:0]     del_end;
    logic               slot_free;

    assign rd_key   = r_dkey[dir_ra];
    assign rd_start = r_dstart[dir_ra];
    assign rd_len   = r_dlen[dir_ra];

    assign len_c      = CNT_W'(r_cmd.len);
    assign run_next   = r_free[r_blk[BLK_W-1:0]] ? (r_run + 1'b1) : '0;
    assign scan_start = r_blk + 1'b1 - len_c;
    assign di_nxt     = r_di + 1'b1;
    assign del_start  = (CNT_W+1)'(rd_start);
    assign del_end    = del_start + (CNT_W+1)'(rd_len);
    assign slot_free  = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_start_block = r_o_start;
    assign o_run_length  = r_o_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_blk        <= n_blk;
        r_run        <= n_run;
        r_di         <= n_di;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_res_len    <= n_res_len;
        r_o_status   <= n_o_status;
        r_o_start    <= n_o_start;
        r_o_len      <= n_o_len;
        if (dir_we) begin
            r_dkey[dir_wa]   <= dir_wkey;
            r_dstart[dir_wa] <= dir_wstart;
            r_dlen[dir_wa]   <= dir_wlen;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_free       = r_free;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_blk        = r_blk;
        n_run        = r_run;
        n_di         = r_di;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_res_len    = r_res_len;
        n_out_valid  = r_out_valid && i_stall;
        n_o_status   = r_o_status;
        n_o_start    = r_o_start;
        n_o_len      = r_o_len;
        o_q_pop      = 1'b0;
        dir_we       = 1'b0;
        dir_wa       = r_count[DIR_IDX_W-1:0];
        dir_wkey     = r_cmd.key;
        dir_wstart   = scan_start[BLK_W-1:0];
        dir_wlen     = len_c;
        dir_ra       = r_di[DIR_IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_q_not_empty) begin
                    o_q_pop      = 1'b1;
                    n_cmd        = i_q_cmd;
                    n_blk        = '0;
                    n_run        = '0;
                    n_di         = '0;
                    n_res_start  = '0;
                    n_res_len    = '0;
                    if (i_q_cmd.op == OP_CREATE) begin
                        if (i_q_cmd.bad_len) begin
                            n_res_status = ST_BAD_LEN;
                            n_state      = S_DONE;
                        end else if (int'(r_count) >= DIR_ENTRIES) begin
                            n_res_status = ST_DIR_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (r_count == '0) begin
                        n_res_status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end

            // one block a cycle; the first run to reach the length is the lowest fit
            S_SCAN: begin
                if (r_blk >= r_cmd.usable) begin
                    n_res_status = ST_NO_SPACE;
                    n_state      = S_DONE;
                end else if (run_next == len_c) begin
                    for (int b = 0; b < BLOCKS; b++) begin
                        if (CNT_W'(b) >= scan_start && CNT_W'(b) <= r_blk) begin
                            n_free[b] = 1'b0;
                        end
                    end
                    dir_we       = 1'b1;
                    n_count      = r_count + 1'b1;
                    n_res_status = ST_CREATED;
                    n_res_start  = scan_start[BLK_W-1:0];
                    n_res_len    = len_c;
                    n_state      = S_DONE;
                end else begin
                    n_run = run_next;
                    n_blk = r_blk + 1'b1;
                end
            end

            S_SEARCH: begin
                if (rd_key == r_cmd.key) begin
                    for (int b = 0; b < BLOCKS; b++) begin
                        if ((CNT_W+1)'(b) >= del_start && (CNT_W+1)'(b) < del_end) begin
                            n_free[b] = 1'b1;
                        end
                    end
                    n_res_status = ST_DELETED;
                    n_res_start  = rd_start;
                    n_res_len    = rd_len;
                    n_state      = S_SHIFT;
                end else if (di_nxt == r_count) begin
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else begin
                    n_di = di_nxt;
                end
            end

            // close the gap: entry i takes entry i+1
            S_SHIFT: begin
                dir_ra = di_nxt[DIR_IDX_W-1:0];
                if (di_nxt < r_count) begin
                    dir_we     = 1'b1;
                    dir_wa     = r_di[DIR_IDX_W-1:0];
                    dir_wkey   = rd_key;
                    dir_wstart = rd_start;
                    dir_wlen   = rd_len;
                    n_di       = di_nxt;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_start   = START_W'(r_res_start);
                    n_o_len     = LEN_W'(r_res_len);
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/contiguous_block_allocator.sv
// Contiguous first-fit block allocator with a file directory.
//
// Request channel: i_valid / o_stall with i_operation (create or delete),
// i_file_key and i_block_count; a beat is taken when i_valid is high and
// o_stall is low. Result channel: o_valid / i_stall with o_status,
// o_start_block and o_run_length, one result beat per request, in order.
// Configuration: i_cfg_valid / o_cfg_ready / i_cfg_data writes the number of
// blocks in use; ready is always high, write only while the block is idle.
//
// Requests are checked for length on entry and wait in a two-beat queue for
// the sequencer. A create walks the free map one block a cycle, up to the end
// of the lowest run that fits or past the last usable block. A delete searches
// the directory one entry a cycle and then shifts the later entries down one
// a cycle. Errors found before a walk go straight to the result. Requests are
// carried out one at a time.
//
// Reset (i_rst_n low, synchronous) frees every block, empties the directory
// and sets the block count to 64. A stalled result holds; the next request
// may be worked on meanwhile but its result waits until the slot frees.
module contiguous_block_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cba_pkg::TOTAL_W-1:0]  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_operation,
    input  logic [cba_pkg::KEY_W-1:0]    i_file_key,
    input  logic [cba_pkg::LEN_W-1:0]    i_block_count,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [cba_pkg::STATUS_W-1:0] o_status,
    output logic [cba_pkg::START_W-1:0]  o_start_block,
    output logic [cba_pkg::LEN_W-1:0]    o_run_length
);
    import cba_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_in_cmd;
    logic q_pop;
    logic q_not_empty;
    t_cmd q_out_cmd;

    cba_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_file_key    (i_file_key),
        .i_block_count (i_block_count),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in_cmd)
    );

    cba_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_cmd       (q_in_cmd),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_cmd       (q_out_cmd)
    );

    cba_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_cmd       (q_out_cmd),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_start_block (o_start_block),
        .o_run_length  (o_run_length)
    );

endmodule

FILE: dv/tb_contiguous_block_allocator.sv
module tb_contiguous_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import cba_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 100;
    localparam logic [KEY_W-1:0] SHARED_KEY = 64'hA5A5_5A5A_0F0F_F0F0;

    typedef struct packed {
        t_status            status;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } t_alloc_outcome;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic [TOTAL_W-1:0]  i_cfg_data    = '0;
    logic                i_valid       = 1'b0;
    logic                i_operation   = 1'b0;
    logic [KEY_W-1:0]    i_file_key    = '0;
    logic [LEN_W-1:0]    i_block_count = '0;
    logic                i_stall       = 1'b0;
    logic                o_cfg_ready;
    logic                o_stall;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [START_W-1:0]  o_start_block;
    logic [LEN_W-1:0]    o_run_length;

    // predictor state
    logic [TOTAL_W-1:0] total_blocks_cfg;
    logic               block_free [BLOCKS];
    logic [KEY_W-1:0]   dir_key    [DIR_ENTRIES];
    int                 dir_start  [DIR_ENTRIES];
    int                 dir_len    [DIR_ENTRIES];
    int                 dir_count;

    t_alloc_outcome pending_outcomes [$];
    int             error_count = 0;
    int             cycle_count = 0;
    int             stall_left  = 0;
    bit             stall_on    = 1'b1;
    bit             idle_on     = 1'b1;

    contiguous_block_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_file_key    (i_file_key),
        .i_block_count (i_block_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_start_block (o_start_block),
        .o_run_length  (o_run_length)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("contiguous_block_allocator test failed");
            $finish;
        end
    end

    // result-side back-pressure, in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 17);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_alloc_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_outcomes.size() == 0) begin
                error_count++;
                $display("%0t unexpected result: status %0d start %0d length %0d",
                         $time, o_status, o_start_block, o_run_length);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status) begin
                    error_count++;
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_status);
                end
                if (o_start_block !== want.start) begin
                    error_count++;
                    $display("%0t start_block mismatch: expected %0d, actual %0d",
                             $time, want.start, o_start_block);
                end
                if (o_run_length !== want.length) begin
                    error_count++;
                    $display("%0t run_length mismatch: expected %0d, actual %0d",
                             $time, want.length, o_run_length);
                end
            end
        end
    end

    function automatic void reset_allocator_model();
        total_blocks_cfg = TOTAL_RESET;
        for (int b = 0; b < BLOCKS; b++) block_free[b] = 1'b1;
        dir_count = 0;
    endfunction

    function automatic t_alloc_outcome predict_allocation(input t_op op,
                                                          input logic [KEY_W-1:0] key,
                                                          input logic [LEN_W-1:0] count);
        t_alloc_outcome outcome;
        int usable;
        int n;
        int hit;
        int idx;
        logic run_ok;
        outcome.status = ST_BAD_LEN;
        outcome.start  = '0;
        outcome.length = '0;
        usable = (int'(total_blocks_cfg) > BLOCKS) ? BLOCKS : int'(total_blocks_cfg);
        n      = int'(count);
        hit    = -1;
        if (op == OP_CREATE) begin
            if (n == 0 || n > usable) begin
                outcome.status = ST_BAD_LEN;
            end else if (dir_count >= DIR_ENTRIES) begin
                outcome.status = ST_DIR_FULL;
            end else begin
                outcome.status = ST_NO_SPACE;
                for (int s = 0; s + n <= usable; s++) begin
                    if (hit < 0) begin
                        run_ok = 1'b1;
                        for (int k = 0; k < n; k++) begin
                            if (!block_free[s + k]) run_ok = 1'b0;
                        end
                        if (run_ok) hit = s;
                    end
                end
                if (hit >= 0) begin
                    for (int k = 0; k < n; k++) block_free[hit + k] = 1'b0;
                    dir_key[dir_count]   = key;
                    dir_start[dir_count] = hit;
                    dir_len[dir_count]   = n;
                    dir_count++;
                    outcome.status = ST_CREATED;
                    outcome.start  = START_W'(hit);
                    outcome.length = LEN_W'(n);
                end
            end
        end else begin
            for (int e = dir_count - 1; e >= 0; e--) begin
                if (dir_key[e] == key) hit = e;
            end
            if (hit < 0) begin
                outcome.status = ST_NOT_FOUND;
            end else begin
                for (int k = 0; k < dir_len[hit]; k++) begin
                    if (dir_start[hit] + k < BLOCKS) block_free[dir_start[hit] + k] = 1'b1;
                end
                outcome.status = ST_DELETED;
                outcome.start  = START_W'(dir_start[hit]);
                outcome.length = LEN_W'(dir_len[hit]);
                for (idx = hit; idx + 1 < dir_count; idx++) begin
                    dir_key[idx]   = dir_key[idx + 1];
                    dir_start[idx] = dir_start[idx + 1];
                    dir_len[idx]   = dir_len[idx + 1];
                end
                dir_count--;
            end
        end
        return outcome;
    endfunction

    // valid is left high after the beat; the next request or a drain decides
    task automatic send_request(input t_op op, input logic [KEY_W-1:0] key,
                                input logic [LEN_W-1:0] count);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_file_key    <= key;
        i_block_count <= count;
        do @(posedge i_clk); while (o_stall);
        pending_outcomes.push_back(predict_allocation(op, key, count));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_total_blocks(input logic [TOTAL_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        total_blocks_cfg = value;
    endtask

    task automatic test_directed_cases();
        send_request(OP_CREATE, 64'h0123_4567_89AB_CDEF, LEN_W'(0));
        send_request(OP_CREATE, 64'h0123_4567_89AB_CDEF, LEN_W'(65));
        send_request(OP_CREATE, '1, '1);
        send_request(OP_CREATE, '1, LEN_W'(64));   // whole disk
        send_request(OP_CREATE, 64'h7, LEN_W'(1)); // no room left
        send_request(OP_DELETE, '0, '0);
        send_request(OP_DELETE, '1, '1);
        // fill the directory exactly, some entries sharing a key
        for (int i = 0; i < DIR_ENTRIES; i++) begin
            send_request(OP_CREATE, (i % 5 == 2) ? SHARED_KEY : {16{4'(i)}}, LEN_W'(4));
        end
        send_request(OP_CREATE, 64'h55, LEN_W'(1)); // directory full
        send_request(OP_CREATE, 64'h55, LEN_W'(0)); // length check wins over full
        send_request(OP_DELETE, SHARED_KEY, LEN_W'(9));
        drain_results();
    endtask

    task automatic test_block_count_limits();
        write_total_blocks(TOTAL_W'(1));
        send_request(OP_CREATE, 64'h1, LEN_W'(1));
        send_request(OP_CREATE, 64'h2, LEN_W'(2));
        write_total_blocks('0);
        send_request(OP_CREATE, 64'h3, LEN_W'(1));
        // blocks above the count are still freed
        while (dir_count != 0) begin
            send_request(OP_DELETE, dir_key[dir_count - 1], LEN_W'($urandom));
        end
        write_total_blocks('1);
        send_request(OP_CREATE, 64'h4, LEN_W'(64));
        send_request(OP_CREATE, 64'h5, LEN_W'(65));
        write_total_blocks(TOTAL_W'(1));
        send_request(OP_DELETE, 64'h4, LEN_W'(0));
        send_request(OP_CREATE, 64'h6, LEN_W'(1));
        drain_results();
    endtask

    task automatic test_random_traffic(input int items, input int create_pct,
                                       input logic [TOTAL_W-1:0] blocks_cfg,
                                       input bit idle);
        int usable;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] count;
        t_op op;
        write_total_blocks(blocks_cfg);
        idle_on = idle;
        stall_on <= idle;
        usable = (int'(blocks_cfg) > BLOCKS) ? BLOCKS : int'(blocks_cfg);
        for (int n = 0; n < items; n++) begin
            key   = {$urandom, $urandom};
            count = LEN_W'($urandom);
            if ($urandom_range(0, 99) < create_pct) begin
                op = OP_CREATE;
                if (dir_count != 0 && $urandom_range(0, 3) == 0)
                    key = dir_key[$urandom_range(0, dir_count - 1)];
                case ($urandom_range(0, 9))
                    0: ; // any length, legal or not
                    1, 2: count = LEN_W'($urandom_range(1, usable));
                    default: count = LEN_W'($urandom_range(1, (usable < 6) ? usable : 6));
                endcase
            end else begin
                op = OP_DELETE;
                if (dir_count != 0 && $urandom_range(0, 9) < 8)
                    key = dir_key[$urandom_range(0, dir_count - 1)];
            end
            send_request(op, key, count);
        end
        drain_results();
    endtask

    initial begin
        reset_allocator_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_block_count_limits();
        test_random_traffic(260, 60, TOTAL_W'(64), 1'b1);
        test_random_traffic(60, 50, TOTAL_W'(1), 1'b1);
        test_random_traffic(150, 55, '1, 1'b0);
        test_random_traffic(150, 55, TOTAL_W'(16), 1'b1);
        test_random_traffic(140, 70, TOTAL_W'(40), 1'b1);
        test_random_traffic(150, 50, TOTAL_W'(64), 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("contiguous_block_allocator test passed");
        end else begin
            $display("contiguous_block_allocator test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/cba_pkg.sv
rtl/cba_front.sv
rtl/cba_queue.sv
rtl/cba_back.sv
rtl/contiguous_block_allocator.sv
dv/tb_contiguous_block_allocator.sv
